[rtl/core/mbss_pkg.sv]
`default_nettype none

package mbss_pkg;

   localparam int LEN_W      = 5;
   localparam int CNT_W      = 3;
   localparam int WORD_BYTES = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_PAT_LO    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_HI    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CARE_MASK = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_LEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_START_OFF = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BASE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RESOLVE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DISP      = 3'd7;

   // result status codes
   localparam logic [1:0] ST_NOT_FOUND = 2'd0;
   localparam logic [1:0] ST_FOUND     = 2'd1;
   localparam logic [1:0] ST_CUT_OFF   = 2'd2;

   typedef struct packed {
      logic [63:0]      pat_lo;
      logic [63:0]      pat_hi;
      logic [15:0]      care_mask;
      logic [LEN_W-1:0] pat_len;
      logic [31:0]      start_off;
      logic [63:0]      base;
      logic             resolve;
      logic [31:0]      disp;
   } cfg_type;

   // result = opa + opb, summed in the output stage
   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] opa;
      logic [33:0] opb;
   } res_type;

endpackage

`default_nettype wire

[rtl/core/mbss_match.sv]
`default_nettype none

module mbss_match #(
   parameter int PATTERN_MAX = 16
) (
   input  logic [7:0]                   win [PATTERN_MAX],
   input  mbss_pkg::cfg_type            cfg,
   input  logic [mbss_pkg::LEN_W-1:0]   eff_len,
   output logic                         hit,
   output logic [mbss_pkg::CNT_W-1:0]   cap_cnt,
   output logic [31:0]                  cap_word
);
   import mbss_pkg::*;

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   logic [127:0]     pat;
   logic             disp_le;
   logic [LEN_W-1:0] room;
   logic [LEN_W-1:0] top_pos;

   assign pat = {cfg.pat_hi, cfg.pat_lo};

   // pattern byte i sits at window entry len-1-i
   always_comb begin
      logic [LEN_W-1:0] pos;
      hit = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pos = eff_len - LEN_W'(i + 1);
         if ((LEN_W'(i) < eff_len) && cfg.care_mask[i]
             && (win[pos[IDX_W-1:0]] != pat[8*i +: 8])) begin
            hit = 1'b0;
         end
      end
   end

   // word bytes already inside the window when the match completes
   assign disp_le = cfg.disp < 32'(eff_len);
   assign room    = eff_len - cfg.disp[LEN_W-1:0];
   assign top_pos = room - LEN_W'(1);

   always_comb begin
      if (!disp_le) begin
         cap_cnt = '0;
      end else if (room >= LEN_W'(WORD_BYTES)) begin
         cap_cnt = CNT_W'(WORD_BYTES);
      end else begin
         cap_cnt = room[CNT_W-1:0];
      end
   end

   always_comb begin
      logic [LEN_W-1:0] pos;
      cap_word = '0;
      for (int c = 0; c < WORD_BYTES; c++) begin
         pos = top_pos - LEN_W'(c);
         if (CNT_W'(c) < cap_cnt) begin
            cap_word[8*c +: 8] = win[pos[IDX_W-1:0]];
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/mbss_scan.sv]
`default_nettype none

module mbss_scan #(
   parameter int PATTERN_MAX = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   input  mbss_pkg::cfg_type   cfg,
   output logic                res_valid,
   output mbss_pkg::res_type   res
);
   import mbss_pkg::*;

   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_CAPTURE,
      PH_DONE
   } phase_type;

   logic [7:0]       win_ff [PATTERN_MAX];
   logic [7:0]       win_in [PATTERN_MAX];
   logic [7:0]       win_shift [PATTERN_MAX];
   logic [31:0]      idx_ff, idx_in;
   phase_type        phase_ff, phase_in;
   logic [31:0]      mstart_ff, mstart_in;
   logic [31:0]      word_ff, word_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [LEN_W-1:0] eff_len;
   logic             hit;
   logic [CNT_W-1:0] cap_cnt;
   logic [31:0]      cap_word;
   logic             reach;
   logic [31:0]      pos_p;
   logic             search_hit;
   logic [33:0]      sum_srch;
   logic [32:0]      sum_md;
   logic             q_here;
   logic [31:0]      word_cap;
   logic [33:0]      sum_cap;

   always_comb begin
      if (cfg.pat_len == '0) begin
         eff_len = LEN_W'(1);
      end else if (cfg.pat_len > LEN_W'(PATTERN_MAX)) begin
         eff_len = LEN_W'(PATTERN_MAX);
      end else begin
         eff_len = cfg.pat_len;
      end
   end

   // window with the new byte shifted in, as seen by the compare
   always_comb begin
      win_shift[0] = data_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win_shift[k] = win_ff[k-1];
      end
   end

   mbss_match #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_match (
      .win      (win_shift),
      .cfg      (cfg),
      .eff_len  (eff_len),
      .hit      (hit),
      .cap_cnt  (cap_cnt),
      .cap_word (cap_word)
   );

   assign reach      = ({1'b0, idx_ff} + 33'd1) >= 33'(eff_len);
   assign pos_p      = idx_ff + 32'd1 - 32'(eff_len);
   assign search_hit = reach && (pos_p >= cfg.start_off) && hit;
   assign sum_srch   = {2'b0, pos_p} + {2'b0, cfg.disp} + {2'b0, cap_word};

   assign sum_md = {1'b0, mstart_ff} + {1'b0, cfg.disp};
   assign q_here = (({1'b0, sum_md} + 34'(cnt_ff)) == {2'b0, idx_ff})
                   && (cnt_ff < CNT_W'(WORD_BYTES));

   always_comb begin
      word_cap = word_ff;
      word_cap[8*cnt_ff[1:0] +: 8] = data_byte;
   end

   assign sum_cap = {1'b0, sum_md} + {2'b0, word_cap};

   always_comb begin
      win_in     = win_shift;
      idx_in     = idx_ff + 32'd1;
      phase_in   = phase_ff;
      mstart_in  = mstart_ff;
      word_in    = word_ff;
      cnt_in     = cnt_ff;
      res_valid  = 1'b0;
      res.status = ST_NOT_FOUND;
      res.opa    = '0;
      res.opb    = '0;

      case (phase_ff)
         PH_SEARCH: begin
            if (search_hit) begin
               mstart_in = pos_p;
               if (!cfg.resolve) begin
                  res_valid  = 1'b1;
                  res.status = ST_FOUND;
                  res.opa    = cfg.base;
                  res.opb    = {2'b0, pos_p};
                  phase_in   = PH_DONE;
               end else begin
                  word_in = cap_word;
                  cnt_in  = cap_cnt;
                  if (cap_cnt == CNT_W'(WORD_BYTES)) begin
                     res_valid  = 1'b1;
                     res.status = ST_FOUND;
                     res.opa    = cfg.base;
                     res.opb    = sum_srch;
                     phase_in   = PH_DONE;
                  end else begin
                     phase_in = PH_CAPTURE;
                  end
               end
            end
         end
         PH_CAPTURE: begin
            if (q_here) begin
               word_in = word_cap;
               cnt_in  = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(WORD_BYTES - 1)) begin
                  res_valid  = 1'b1;
                  res.status = ST_FOUND;
                  res.opa    = cfg.base;
                  res.opb    = sum_cap;
                  phase_in   = PH_DONE;
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // end of region: report what is still open, then drop the region state
      if (last_byte) begin
         if (!res_valid && (phase_in != PH_DONE)) begin
            res_valid  = 1'b1;
            res.status = (phase_in == PH_CAPTURE) ? ST_CUT_OFF : ST_NOT_FOUND;
         end
         for (int k = 0; k < PATTERN_MAX; k++) begin
            win_in[k] = 8'h00;
         end
         idx_in    = '0;
         phase_in  = PH_SEARCH;
         mstart_in = '0;
         word_in   = '0;
         cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PATTERN_MAX; k++) begin
            win_ff[k] <= 8'h00;
         end
         idx_ff    <= '0;
         phase_ff  <= PH_SEARCH;
         mstart_ff <= '0;
         word_ff   <= '0;
         cnt_ff    <= '0;
      end else if (step) begin
         win_ff    <= win_in;
         idx_ff    <= idx_in;
         phase_ff  <= phase_in;
         mstart_ff <= mstart_in;
         word_ff   <= word_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/mbss_out.sv]
`default_nettype none

module mbss_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               res_valid,
   input  mbss_pkg::res_type  res,
   output logic               accept_ok,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [63:0]        rsp_result_address
);
   import mbss_pkg::*;

   logic        sum_valid_ff;
   res_type     sum_res_ff;
   logic        rsp_valid_ff;
   logic [1:0]  status_ff;
   logic [63:0] addr_ff;
   logic        out_ok;

   assign out_ok    = !rsp_valid_ff || rsp_ready;
   assign accept_ok = !sum_valid_ff || out_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept_ok) begin
            sum_valid_ff <= step && res_valid;
         end
         if (out_ok) begin
            rsp_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         sum_res_ff <= res;
      end
      if (sum_valid_ff && out_ok) begin
         status_ff <= sum_res_ff.status;
         addr_ff   <= sum_res_ff.opa + 64'(sum_res_ff.opb);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_result_address = addr_ff;

endmodule

`default_nettype wire

[rtl/core/masked_byte_signature_search_top.sv]
// Wildcard byte-pattern scan over a region streamed one byte per item.
// req_*: one region byte per item, req_last_byte marks the final byte of a
// region. rsp_*: at most one item per region: found (match address, or the
// resolved relative pointer in pointer mode), not found, or pointer word cut
// off by the region end. Not found and cut off come with the last byte.
// csr_*: write-only registers, indexes 0..7: pattern low/high, care mask,
// pattern length, start offset, region base, pointer mode, displacement.
// Write them between items; a write takes effect for the next byte.
// Throughput: one byte per cycle unless rsp_ready stalls the output. The
// window compare, capture and state update sit in one stage between the input
// register and the sum register. A result passes the input register, the scan
// stage, the sum register and the 64-bit sum stage, then reaches rsp_valid.
// A stalled rsp_ready fills the sum and output registers; req_ready falls
// only when both are full and the input register holds a byte.
// Reset (synchronous) restores register defaults, drops all items in flight
// and starts a fresh region.
`default_nettype none

module masked_byte_signature_search_top #(
   parameter int PATTERN_MAX = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [63:0]                         rsp_result_address,
   input  logic                                csr_wr_en,
   input  logic [mbss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mbss_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mbss_pkg::*;

   cfg_type     cfg_ff;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        accept_ok;
   logic        step;
   logic        res_valid;
   res_type     res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pat_lo    <= '0;
         cfg_ff.pat_hi    <= '0;
         cfg_ff.care_mask <= '0;
         cfg_ff.pat_len   <= LEN_W'(1);
         cfg_ff.start_off <= '0;
         cfg_ff.base      <= '0;
         cfg_ff.resolve   <= 1'b0;
         cfg_ff.disp      <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_PAT_LO:    cfg_ff.pat_lo    <= csr_wdata;
            REG_PAT_HI:    cfg_ff.pat_hi    <= csr_wdata;
            REG_CARE_MASK: cfg_ff.care_mask <= csr_wdata[15:0];
            REG_PAT_LEN:   cfg_ff.pat_len   <= csr_wdata[LEN_W-1:0];
            REG_START_OFF: cfg_ff.start_off <= csr_wdata[31:0];
            REG_BASE:      cfg_ff.base      <= csr_wdata;
            REG_RESOLVE:   cfg_ff.resolve   <= csr_wdata[0];
            REG_DISP:      cfg_ff.disp      <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   // input register: hold the item until the scan stage takes it
   assign req_ready = !in_valid_ff || accept_ok;
   assign step      = in_valid_ff && accept_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   mbss_scan #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   mbss_out u_out (
      .clock              (clock),
      .reset              (reset),
      .step               (step),
      .res_valid          (res_valid),
      .res                (res),
      .accept_ok          (accept_ok),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address)
   );

endmodule

`default_nettype wire

[tb/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mbss_pkg::*;

   localparam int WINDOW_DEPTH   = 16;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int RANDOM_BYTES   = 400;

   typedef enum logic [1:0] {SCAN_SEARCH, SCAN_CAPTURE, SCAN_DONE} scan_phase_type;

   typedef struct {
      logic [1:0]  status;
      logic [63:0] address;
   } scan_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_data_byte;
   logic                  req_last_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [1:0]            rsp_status;
   logic [63:0]           rsp_result_address;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor copy of the registers and the scan state
   cfg_type        scan_cfg;
   logic [7:0]     recent_bytes [WINDOW_DEPTH];
   logic [31:0]    scan_index;
   scan_phase_type scan_phase;
   logic [31:0]    match_pos;
   logic [31:0]    word_acc;
   logic [2:0]     word_count;

   scan_result_type expected_results [$];
   scan_result_type oldest;

   int  error_count = 0;
   int  cycle_count = 0;
   int  sent_bytes = 0;
   bit  sender_gaps = 1'b0;
   bit  hold_rsp_request = 1'b0;
   int  rsp_stall_left = 0;
   int  rsp_free_left = 0;

   masked_byte_signature_search_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_scan();
      for (int k = 0; k < WINDOW_DEPTH; k++) recent_bytes[k] = 8'h00;
      scan_index = '0;
      scan_phase = SCAN_SEARCH;
      match_pos  = '0;
      word_acc   = '0;
      word_count = '0;
   endfunction

   function automatic int eff_pattern_length();
      int n;
      n = int'(scan_cfg.pat_len);
      if (n == 0) n = 1;
      if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
      return n;
   endfunction

   function automatic logic [7:0] pattern_byte(input int idx);
      logic [127:0] all_bytes;
      all_bytes = {scan_cfg.pat_hi, scan_cfg.pat_lo};
      return all_bytes[8*idx +: 8];
   endfunction

   // newest byte sits at entry 0, so pattern position i is entry n-1-i
   function automatic bit window_hit(input int n);
      for (int i = 0; i < n; i++) begin
         if (scan_cfg.care_mask[i] && recent_bytes[n-1-i] != pattern_byte(i)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void push_result(input logic [1:0] status, input logic [63:0] address);
      scan_result_type r;
      r.status  = status;
      r.address = address;
      expected_results.push_back(r);
   endfunction

   function automatic logic [63:0] resolved_pointer();
      return scan_cfg.base + {32'd0, match_pos} + {32'd0, scan_cfg.disp} + {32'd0, word_acc};
   endfunction

   function automatic void predict_scan(input logic [7:0] b, input logic last);
      logic [31:0] cur;
      logic [31:0] p;
      logic [63:0] q;
      logic [63:0] back;
      int          n;
      bit          reported;
      cur = scan_index;
      reported = 1'b0;
      sent_bytes++;
      for (int k = WINDOW_DEPTH - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
      recent_bytes[0] = b;

      if (scan_phase == SCAN_SEARCH) begin
         n = eff_pattern_length();
         if ({32'd0, cur} + 64'd1 >= 64'(n)) begin
            p = cur + 32'd1 - 32'(n);
            if (p >= scan_cfg.start_off && window_hit(n)) begin
               match_pos = p;
               if (!scan_cfg.resolve) begin
                  push_result(ST_FOUND, scan_cfg.base + {32'd0, p});
                  reported = 1'b1;
                  scan_phase = SCAN_DONE;
               end else begin
                  // take whatever word bytes are already in the window
                  word_acc = '0;
                  word_count = '0;
                  while (word_count < 3'd4) begin
                     q = {32'd0, p} + {32'd0, scan_cfg.disp} + {61'd0, word_count};
                     if (q > {32'd0, cur}) break;
                     back = {32'd0, cur} - q;
                     if (back >= 64'(WINDOW_DEPTH)) break;
                     word_acc |= {24'd0, recent_bytes[back[3:0]]} << (8 * word_count);
                     word_count++;
                  end
                  if (word_count == 3'd4) begin
                     push_result(ST_FOUND, resolved_pointer());
                     reported = 1'b1;
                     scan_phase = SCAN_DONE;
                  end else begin
                     scan_phase = SCAN_CAPTURE;
                  end
               end
            end
         end
      end else if (scan_phase == SCAN_CAPTURE) begin
         q = {32'd0, match_pos} + {32'd0, scan_cfg.disp} + {62'd0, word_count[1:0]};
         if (q == {32'd0, cur} && word_count < 3'd4) begin
            word_acc |= {24'd0, b} << (8 * word_count);
            word_count++;
            if (word_count == 3'd4) begin
               push_result(ST_FOUND, resolved_pointer());
               reported = 1'b1;
               scan_phase = SCAN_DONE;
            end
         end
      end

      if (last) begin
         if (!reported) begin
            if (scan_phase == SCAN_SEARCH) push_result(ST_NOT_FOUND, 64'd0);
            else if (scan_phase == SCAN_CAPTURE) push_result(ST_CUT_OFF, 64'd0);
         end
         clear_scan();
      end else begin
         scan_index = cur + 32'd1;
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      predict_scan(b, last);
      gap = (sender_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid, wait for all results, then let the pipeline empty
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input cfg_type c);
      logic [CSR_DATA_W-1:0] reg_value [8];
      logic [63:0]           junk;
      junk = {$urandom, $urandom};
      // upper bits of narrow registers carry junk that must be dropped
      reg_value[REG_PAT_LO]    = c.pat_lo;
      reg_value[REG_PAT_HI]    = c.pat_hi;
      reg_value[REG_CARE_MASK] = {junk[63:16], c.care_mask};
      reg_value[REG_PAT_LEN]   = {junk[63:LEN_W], c.pat_len};
      reg_value[REG_START_OFF] = {junk[63:32], c.start_off};
      reg_value[REG_BASE]      = c.base;
      reg_value[REG_RESOLVE]   = {junk[63:1], c.resolve};
      reg_value[REG_DISP]      = {junk[63:32], c.disp};
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= reg_value[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      scan_cfg = c;
   endtask

   task automatic reconfigure(input cfg_type c);
      wait_drain();
      program_regs(c);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_defaults();
      // length one with no care bits matches at offset zero
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_plain_wildcards();
      cfg_type c;
      c = '0;
      c.pat_lo    = 64'h0000_0000_0000_BBAA;
      c.care_mask = 16'hFFFB;
      c.pat_len   = 5'd3;
      c.start_off = 32'd1;
      c.base      = 64'hFFFF_FFFF_FFFF_FFFE;
      reconfigure(c);
      // hit at zero is before the start offset; next hit completes on the last byte
      send_byte(8'hAA, 1'b0);
      send_byte(8'hBB, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hBB, 1'b0);
      send_byte(8'hFF, 1'b1);

      // region shorter than a full sixteen byte pattern
      c.pat_lo    = 64'h0807_0605_0403_0201;
      c.pat_hi    = 64'hFFFE_FDFC_FBFA_F9F8;
      c.care_mask = 16'hFFFF;
      c.pat_len   = 5'd16;
      c.start_off = 32'd0;
      reconfigure(c);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b1);

      // zero length behaves as one, care bits beyond it do not count
      c.pat_lo    = 64'h0000_0000_0000_00FF;
      c.pat_hi    = '0;
      c.pat_len   = 5'd0;
      c.base      = 64'h0000_0000_0000_1000;
      reconfigure(c);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_pointer_resolve();
      cfg_type c;
      c = '0;
      c.pat_lo    = 64'h0000_0000_0000_8D4C;
      c.care_mask = 16'h0003;
      c.pat_len   = 5'd2;
      c.base      = 64'h0000_7FF0_0000_0000;
      c.resolve   = 1'b1;
      c.disp      = 32'd0;
      reconfigure(c);
      // word overlaps the pattern and finishes on the last byte
      send_byte(8'h4C, 1'b0);
      send_byte(8'h8D, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b1);

      // word runs past the region end
      c.disp = 32'd3;
      reconfigure(c);
      send_byte(8'h00, 1'b0);
      send_byte(8'h4C, 1'b0);
      send_byte(8'h8D, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h01, 1'b1);
   endtask

   task automatic test_midregion_write();
      cfg_type c;
      c = scan_cfg;
      send_byte(8'h4C, 1'b0);
      c.resolve = 1'b0;
      reconfigure(c);
      send_byte(8'h8D, 1'b1);
   endtask

   task automatic test_output_backpressure();
      cfg_type c;
      c = '0;
      c.pat_lo    = 64'h0000_0000_0000_005A;
      c.care_mask = 16'h0001;
      c.pat_len   = 5'd1;
      c.base      = {$urandom, $urandom};
      reconfigure(c);
      sender_gaps = 1'b0;
      hold_rsp_request = 1'b1;
      // one-byte regions each give a result, so the block backs up
      repeat (30) send_byte($urandom_range(0, 1) ? 8'h5A : 8'($urandom), 1'b1);
      wait_drain();
   endtask

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.pat_lo = {$urandom, $urandom};
      c.pat_hi = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0:       c.care_mask = 16'hFFFF;
         1:       c.care_mask = 16'h0000;
         default: c.care_mask = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0:       c.pat_len = 5'd0;
         1:       c.pat_len = 5'd1;
         2:       c.pat_len = 5'd16;
         3:       c.pat_len = 5'($urandom_range(17, 31));
         default: c.pat_len = 5'($urandom_range(2, 15));
      endcase
      case ($urandom_range(0, 7))
         0:       c.start_off = 32'hFFFF_FFFF;
         1:       c.start_off = 32'd0;
         default: c.start_off = $urandom_range(0, 12);
      endcase
      case ($urandom_range(0, 5))
         0:       c.base = 64'hFFFF_FFFF_FFFF_FFFF;
         1:       c.base = 64'd0;
         default: c.base = {$urandom, $urandom};
      endcase
      c.resolve = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
         0:       c.disp = 32'hFFFF_FFFF;
         1:       c.disp = 32'd0;
         2:       c.disp = $urandom_range(0, 15);
         default: c.disp = $urandom_range(0, 24);
      endcase
      return c;
   endfunction

   task automatic send_random_region();
      logic [7:0] region_data [128];
      int         n;
      int         pos;
      int         need;
      int         len;
      int         kind;
      n    = eff_pattern_length();
      kind = $urandom_range(0, 9);
      pos  = (scan_cfg.start_off < 24) ? int'(scan_cfg.start_off) + $urandom_range(0, 6)
                                       : $urandom_range(0, 6);
      need = pos + n;
      if (scan_cfg.resolve && scan_cfg.disp < 40 && pos + int'(scan_cfg.disp) + 4 > need)
         need = pos + int'(scan_cfg.disp) + 4;
      len = need + $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) len = need - $urandom_range(1, 3);
      if (kind == 8) len = $urandom_range(1, 3);
      else if (kind >= 7) len = $urandom_range(1, 40);
      if (len < 1) len = 1;
      for (int i = 0; i < len; i++)
         region_data[i] = (kind == 9 || $urandom_range(0, 3) == 0)
                          ? pattern_byte($urandom_range(0, 15)) : 8'($urandom);
      // plant the cared bytes of the pattern at pos
      if (kind <= 6)
         for (int i = 0; i < n; i++)
            if (pos + i < len && scan_cfg.care_mask[i]) region_data[pos+i] = pattern_byte(i);
      for (int i = 0; i < len; i++) send_byte(region_data[i], i == len - 1);
   endtask

   task automatic test_random_regions();
      int bytes_target;
      bytes_target = sent_bytes + RANDOM_BYTES;
      while (sent_bytes < bytes_target) begin
         reconfigure(random_cfg());
         sender_gaps = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 6)) send_random_region();
      end
   endtask

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected item: status %0d address %h",
                     $time, rsp_status, rsp_result_address);
            error_count++;
         end else begin
            oldest = expected_results.pop_front();
            if (rsp_status !== oldest.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, oldest.status, rsp_status);
               error_count++;
            end
            if (rsp_result_address !== oldest.address) begin
               $display("%0t: result_address mismatch: expected %h actual %h",
                        $time, oldest.address, rsp_result_address);
               error_count++;
            end
         end
      end
   end

   // receiver: random stalls, quiet stretches, and one long hold on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (rsp_stall_left != 0) begin
            rsp_ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_free_left != 0) rsp_free_left--;
            else if ($urandom_range(0, 19) == 0) rsp_free_left = $urandom_range(20, 80);
            else if ($urandom_range(0, 2) == 0) rsp_stall_left = gap_len();
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("masked_byte_signature_search_top regression: fail");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      scan_cfg         = '0;
      scan_cfg.pat_len = 5'd1;
      clear_scan();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      sender_gaps = 1'b1;
      test_reset_defaults();
      test_plain_wildcards();
      test_pointer_resolve();
      test_midregion_write();
      test_output_backpressure();
      test_random_regions();
      wait_drain();

      if (error_count == 0)
         $display("masked_byte_signature_search_top regression: pass");
      else
         $display("masked_byte_signature_search_top regression: fail");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/mbss_pkg.sv
rtl/core/mbss_match.sv
rtl/core/mbss_scan.sv
rtl/core/mbss_out.sv
rtl/core/masked_byte_signature_search_top.sv
tb/tb_top.sv
